/* hw/rtl/lccw_pkg.sv */
// Package: shared types and constants for the LED chain chase waveform block.
package lccw_pkg;

    localparam int COLOR_W = 24;
    localparam int BIT_W   = 5;
    localparam int TICK_W  = 26;
    localparam int POS_W   = 5;
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;

    localparam logic [BIT_W-1:0] BIT_TOP = 5'd23;

    localparam logic [23:0] FG_COLOR_RST   = 24'h000F00;
    localparam logic [23:0] BG_COLOR_RST   = 24'h00000F;
    localparam logic [9:0]  ONE_HIGH_RST   = 10'd140;
    localparam logic [9:0]  ONE_LOW_RST    = 10'd160;
    localparam logic [9:0]  ZERO_HIGH_RST  = 10'd70;
    localparam logic [9:0]  ZERO_LOW_RST   = 10'd120;
    localparam logic [15:0] LATCH_RST      = 16'd12000;
    localparam logic [25:0] FRAME_WAIT_RST = 26'd4000000;

    typedef enum logic [1:0] {
        PH_HIGH,
        PH_LOW,
        PH_LATCH,
        PH_WAIT
    } phase_t;

    typedef enum logic [2:0] {
        REG_FG_COLOR,
        REG_BG_COLOR,
        REG_ONE_HIGH,
        REG_ONE_LOW,
        REG_ZERO_HIGH,
        REG_ZERO_LOW,
        REG_LATCH,
        REG_FRAME_WAIT
    } reg_idx_t;

    typedef struct packed {
        logic [23:0] fg_color;
        logic [23:0] bg_color;
        logic [9:0]  one_high;
        logic [9:0]  one_low;
        logic [9:0]  zero_high;
        logic [9:0]  zero_low;
        logic [15:0] latch;
        logic [25:0] frame_wait;
    } cfg_t;

    // Head of the front queue as seen by the back end
    typedef struct packed {
        logic valid;
        logic tick_enable;
    } q_word_t;

endpackage

/* hw/rtl/lccw_if.sv */
// Interfaces: tick input channel and waveform result channel.
interface lccw_in_if;
    logic valid;
    logic ready;
    logic tick_enable;

    modport source (output valid, output tick_enable, input ready);
    modport sink (input valid, input tick_enable, output ready);
endinterface

interface lccw_out_if;
    logic       valid;
    logic       ready;
    logic       line_level;
    logic [4:0] lit_position;
    logic       frame_done;

    modport source (output valid, output line_level, output lit_position,
                    output frame_done, input ready);
    modport sink (input valid, input line_level, input lit_position,
                  input frame_done, output ready);
endinterface

/* hw/rtl/lccw_cfg.sv */
// Configuration register file behind the APB-style port.
module lccw_cfg (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [lccw_pkg::ADDR_W-1:0] paddr,
    input  logic [lccw_pkg::DATA_W-1:0] pwdata,
    output logic [lccw_pkg::DATA_W-1:0] prdata,
    output logic                      pready,
    output lccw_pkg::cfg_t            cfg
);

    logic [23:0] fg_color_reg;
    logic [23:0] bg_color_reg;
    logic [9:0]  one_high_reg;
    logic [9:0]  one_low_reg;
    logic [9:0]  zero_high_reg;
    logic [9:0]  zero_low_reg;
    logic [15:0] latch_reg;
    logic [25:0] frame_wait_reg;

    lccw_pkg::reg_idx_t idx;
    logic               wr_en;

    assign pready = 1'b1;
    assign idx    = lccw_pkg::reg_idx_t'(paddr[4:2]);
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fg_color_reg   <= lccw_pkg::FG_COLOR_RST;
            bg_color_reg   <= lccw_pkg::BG_COLOR_RST;
            one_high_reg   <= lccw_pkg::ONE_HIGH_RST;
            one_low_reg    <= lccw_pkg::ONE_LOW_RST;
            zero_high_reg  <= lccw_pkg::ZERO_HIGH_RST;
            zero_low_reg   <= lccw_pkg::ZERO_LOW_RST;
            latch_reg      <= lccw_pkg::LATCH_RST;
            frame_wait_reg <= lccw_pkg::FRAME_WAIT_RST;
        end
        else if (wr_en)
        begin
            unique case (idx)
                lccw_pkg::REG_FG_COLOR:   fg_color_reg   <= pwdata[23:0];
                lccw_pkg::REG_BG_COLOR:   bg_color_reg   <= pwdata[23:0];
                lccw_pkg::REG_ONE_HIGH:   one_high_reg   <= pwdata[9:0];
                lccw_pkg::REG_ONE_LOW:    one_low_reg    <= pwdata[9:0];
                lccw_pkg::REG_ZERO_HIGH:  zero_high_reg  <= pwdata[9:0];
                lccw_pkg::REG_ZERO_LOW:   zero_low_reg   <= pwdata[9:0];
                lccw_pkg::REG_LATCH:      latch_reg      <= pwdata[15:0];
                lccw_pkg::REG_FRAME_WAIT: frame_wait_reg <= pwdata[25:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            lccw_pkg::REG_FG_COLOR:   prdata = {8'd0, fg_color_reg};
            lccw_pkg::REG_BG_COLOR:   prdata = {8'd0, bg_color_reg};
            lccw_pkg::REG_ONE_HIGH:   prdata = {22'd0, one_high_reg};
            lccw_pkg::REG_ONE_LOW:    prdata = {22'd0, one_low_reg};
            lccw_pkg::REG_ZERO_HIGH:  prdata = {22'd0, zero_high_reg};
            lccw_pkg::REG_ZERO_LOW:   prdata = {22'd0, zero_low_reg};
            lccw_pkg::REG_LATCH:      prdata = {16'd0, latch_reg};
            lccw_pkg::REG_FRAME_WAIT: prdata = {6'd0, frame_wait_reg};
            default:                  prdata = '0;
        endcase
    end

    assign cfg.fg_color   = fg_color_reg;
    assign cfg.bg_color   = bg_color_reg;
    assign cfg.one_high   = one_high_reg;
    assign cfg.one_low    = one_low_reg;
    assign cfg.zero_high  = zero_high_reg;
    assign cfg.zero_low   = zero_low_reg;
    assign cfg.latch      = latch_reg;
    assign cfg.frame_wait = frame_wait_reg;

endmodule

/* hw/rtl/lccw_front.sv */
// Front end: accepts tick words into a two-entry queue for the back end.
module lccw_front (
    input  logic              clk,
    input  logic              rst_n,
    lccw_in_if.sink           tick_in,
    input  logic              q_pop,
    output lccw_pkg::q_word_t q_word
);

    localparam int            Q_DEPTH = 2;
    localparam logic [1:0]    Q_FULL  = 2'(Q_DEPTH);

    logic       slot_reg [Q_DEPTH];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    logic       push;

    assign tick_in.ready = (cnt_reg != Q_FULL);
    assign push          = tick_in.valid && tick_in.ready;

    assign q_word.valid       = (cnt_reg != 2'd0);
    assign q_word.tick_enable = slot_reg[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !q_pop)
            cnt_next = cnt_reg + 2'd1;
        else if (!push && q_pop)
            cnt_next = cnt_reg - 2'd1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= tick_in.tick_enable;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (q_pop)
                rd_ptr_reg <= ~rd_ptr_reg;
        end
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= Q_FULL)
        else $error("queue count beyond depth");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> cnt_reg != 2'd0)
        else $error("pop from empty queue");

    a_push_only: assert property (@(posedge clk) disable iff (!rst_n)
        push && !q_pop |=> cnt_reg == $past(cnt_reg) + 2'd1)
        else $error("queue count did not follow push");

endmodule

/* hw/rtl/lccw_back.sv */
// Back end: waveform sequencer stepping one tick per queue word with tick_enable set, with output register.
module lccw_back #(
    parameter int CHAIN_LENGTH = 24
) (
    input  logic              clk,
    input  logic              rst_n,
    input  lccw_pkg::cfg_t    cfg,
    input  lccw_pkg::q_word_t q_word,
    output logic              q_pop,
    lccw_out_if.source        wave_out
);

    localparam int IDX_W = (CHAIN_LENGTH > 1) ? $clog2(CHAIN_LENGTH) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CHAIN_LENGTH - 1);

    lccw_pkg::phase_t phase_reg, phase_next;
    logic [IDX_W-1:0]            lit_idx_reg, lit_idx_next;
    logic [IDX_W-1:0]            pixel_cnt_reg, pixel_cnt_next;
    logic [lccw_pkg::BIT_W-1:0]  bit_cnt_reg, bit_cnt_next;
    logic [lccw_pkg::TICK_W-1:0] tick_cnt_reg, tick_cnt_next;
    logic                        done_next;

    logic                        out_valid_reg;
    logic                        line_reg;
    logic [lccw_pkg::POS_W-1:0]  pos_reg;
    logic                        done_reg;

    logic                        step;
    logic                        run;
    logic [23:0]                 color;
    logic                        cur_bit;
    logic [lccw_pkg::TICK_W-1:0] dur_raw;
    logic [lccw_pkg::TICK_W-1:0] dur;
    logic [lccw_pkg::TICK_W:0]   tick_inc;
    logic                        expired;
    logic                        last_bit;
    logic                        last_pix;
    logic                        wait_zero;

    assign step  = q_word.valid && (!out_valid_reg || wave_out.ready);
    assign q_pop = step;
    assign run   = step && q_word.tick_enable;

    assign color     = (pixel_cnt_reg == lit_idx_reg) ? cfg.fg_color : cfg.bg_color;
    assign cur_bit   = color[bit_cnt_reg];
    assign tick_inc  = {1'b0, tick_cnt_reg} + 27'd1;
    assign last_bit  = (bit_cnt_reg == '0);
    assign last_pix  = (pixel_cnt_reg == LAST_IDX);
    assign wait_zero = (cfg.frame_wait == '0);

    always_comb
    begin
        unique case (phase_reg)
            lccw_pkg::PH_HIGH:
                dur_raw = 26'(cur_bit ? cfg.one_high : cfg.zero_high);
            lccw_pkg::PH_LOW:
                dur_raw = 26'(cur_bit ? cfg.one_low : cfg.zero_low);
            lccw_pkg::PH_LATCH:
                dur_raw = 26'(cfg.latch);
            lccw_pkg::PH_WAIT:
                dur_raw = cfg.frame_wait;
            default:
                dur_raw = '0;
        endcase
        // bit and latch periods last at least one tick; the wait may be empty
        if (dur_raw == '0 && phase_reg != lccw_pkg::PH_WAIT)
            dur = 26'd1;
        else
            dur = dur_raw;
    end

    assign expired = (tick_inc >= {1'b0, dur});

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (run && expired)
        begin
            unique case (phase_reg)
                lccw_pkg::PH_HIGH:  phase_next = lccw_pkg::PH_LOW;
                lccw_pkg::PH_LOW:
                    phase_next = (last_bit && last_pix) ? lccw_pkg::PH_LATCH
                                                        : lccw_pkg::PH_HIGH;
                lccw_pkg::PH_LATCH:
                    phase_next = wait_zero ? lccw_pkg::PH_HIGH : lccw_pkg::PH_WAIT;
                lccw_pkg::PH_WAIT:  phase_next = lccw_pkg::PH_HIGH;
                default:            phase_next = lccw_pkg::PH_HIGH;
            endcase
        end
    end

    // counters and frame-done flag
    always_comb
    begin
        lit_idx_next   = lit_idx_reg;
        pixel_cnt_next = pixel_cnt_reg;
        bit_cnt_next   = bit_cnt_reg;
        tick_cnt_next  = tick_cnt_reg;
        done_next      = 1'b0;
        if (run)
        begin
            tick_cnt_next = expired ? '0 : tick_inc[lccw_pkg::TICK_W-1:0];
            if (expired)
            begin
                unique case (phase_reg)
                    lccw_pkg::PH_HIGH: ;
                    lccw_pkg::PH_LOW:
                    begin
                        if (last_bit)
                        begin
                            bit_cnt_next   = lccw_pkg::BIT_TOP;
                            pixel_cnt_next = last_pix ? '0 : pixel_cnt_reg + 1'b1;
                        end
                        else
                            bit_cnt_next = bit_cnt_reg - 1'b1;
                    end
                    lccw_pkg::PH_LATCH:
                    begin
                        if (wait_zero)
                        begin
                            lit_idx_next = (lit_idx_reg == LAST_IDX) ? '0
                                                                     : lit_idx_reg + 1'b1;
                            done_next    = 1'b1;
                        end
                    end
                    lccw_pkg::PH_WAIT:
                    begin
                        lit_idx_next = (lit_idx_reg == LAST_IDX) ? '0 : lit_idx_reg + 1'b1;
                        done_next    = 1'b1;
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= lccw_pkg::PH_HIGH;
            lit_idx_reg   <= '0;
            pixel_cnt_reg <= '0;
            bit_cnt_reg   <= lccw_pkg::BIT_TOP;
            tick_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            lit_idx_reg   <= lit_idx_next;
            pixel_cnt_reg <= pixel_cnt_next;
            bit_cnt_reg   <= bit_cnt_next;
            tick_cnt_reg  <= tick_cnt_next;
            if (step)
                out_valid_reg <= 1'b1;
            else if (wave_out.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // level is the one driven during this tick, position the one after it
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            line_reg <= (phase_reg == lccw_pkg::PH_HIGH);
            pos_reg  <= lccw_pkg::POS_W'(lit_idx_next);
            done_reg <= done_next;
        end
    end

    assign wave_out.valid        = out_valid_reg;
    assign wave_out.line_level   = line_reg;
    assign wave_out.lit_position = pos_reg;
    assign wave_out.frame_done   = done_reg;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !run |=> $stable(phase_reg) && $stable(tick_cnt_reg) && $stable(lit_idx_reg)
                 && $stable(pixel_cnt_reg) && $stable(bit_cnt_reg))
        else $error("sequencer state moved without an enabled tick");

    a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
        run && done_next |=> phase_reg == lccw_pkg::PH_HIGH && tick_cnt_reg == '0
                             && pixel_cnt_reg == '0 && bit_cnt_reg == lccw_pkg::BIT_TOP)
        else $error("frame did not restart at first bit");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        lit_idx_reg <= LAST_IDX && pixel_cnt_reg <= LAST_IDX
        && bit_cnt_reg <= lccw_pkg::BIT_TOP)
        else $error("counter out of range");

endmodule

/* hw/rtl/led_chain_chase_waveform.sv */
// Top level: LED chain chase waveform driver with APB configuration.
//
//  channel    dir  handshake        payload
//  tick_in    in   valid/ready      tick_enable
//  wave_out   out  valid/ready      line_level, lit_position, frame_done
//  apb        in   psel/penable     paddr, pwdata -> prdata (pready tied high)
//
// One tick word is taken every cycle while the queue has room; its result is registered in the
// front queue, then in the back end's output register, before it is valid to the receiver.
// Reset puts the sequencer at the high phase of bit 23 of pixel 0, lit position 0.
// A stalled result holds in the output register while the two-entry queue keeps
// accepting; tick_in.ready drops once the queue is full.
module led_chain_chase_waveform #(
    parameter int CHAIN_LENGTH = 24
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [lccw_pkg::ADDR_W-1:0] paddr,
    input  logic [lccw_pkg::DATA_W-1:0] pwdata,
    output logic [lccw_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    lccw_in_if.sink                     tick_in,
    lccw_out_if.source                  wave_out
);

    lccw_pkg::cfg_t    cfg;
    lccw_pkg::q_word_t q_word;
    logic              q_pop;

    lccw_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    lccw_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .tick_in (tick_in),
        .q_pop   (q_pop),
        .q_word  (q_word)
    );

    lccw_back #(
        .CHAIN_LENGTH (CHAIN_LENGTH)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .q_word   (q_word),
        .q_pop    (q_pop),
        .wave_out (wave_out)
    );

endmodule
